// ----- sv/cdfi_pkg.sv -----
package cdfi_pkg;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned CAP_W     = 5;
  localparam int unsigned DEPTH_DEF = 16;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic [1:0] {
    CMD_INSERT    = 2'd0,
    CMD_REM_FRONT = 2'd1,
    CMD_REM_REAR  = 2'd2,
    CMD_LIST      = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                      command;
    logic signed [WORD_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    status_t                   status;
    logic signed [WORD_W-1:0]  word;
    logic                      last;
  } out_word_t;

  typedef struct packed {
    logic [CAP_W-1:0] capacity;
  } cfg_word_t;

  typedef struct packed {
    logic cfg_wr;
    logic exec;
    logic load;
    logic next;
  } dp_cmd_t;

  typedef struct packed {
    logic go_read;
    logic more;
  } dp_stat_t;

endpackage

// ----- sv/cdfi_chan_if.sv -----
interface cdfi_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- sv/circular_deque_front_insert.sv -----
// An insert, an overflow, an underflow or an empty listing has its word valid in the cycle after
// acceptance; a removal reads it in S_READ first, as the slot memory has a registered read.
// A listing gives one word per memory read, each shown in S_OUT until the sink is ready.
// The next command is taken in the cycle after the final word of the previous one is accepted.
// Synchronous active-low reset empties the queue and sets the capacity to 16; slot contents are
// not cleared, and a capacity write empties the queue as well.
module circular_deque_front_insert import cdfi_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input logic           clk,
  input logic           rst_n,
  cdfi_chan_if.sink     in_ch,
  cdfi_chan_if.source   out_ch,
  cdfi_chan_if.sink     cfg_ch
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  cdfi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .cfg_valid (cfg_ch.valid),
    .cfg_ready (cfg_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  cdfi_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_ch.data),
    .cfg_data (cfg_ch.data),
    .out_data (out_ch.data)
  );

endmodule

// ----- sv/cdfi_ram.sv -----
module cdfi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/cdfi_ctrl.sv -----
module cdfi_ctrl import cdfi_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_OUT  = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cfg_ready = 1'b1;
        in_ready  = !cfg_valid;
        if (cfg_valid) begin
          cmd.cfg_wr = 1'b1;
        end else if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = stat.go_read ? S_READ : S_OUT;
        end
      end
      S_READ: begin
        cmd.load  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (stat.more) begin
            cmd.next  = 1'b1;
            state_nxt = S_READ;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- sv/cdfi_dp.sv -----
module cdfi_dp import cdfi_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  input  in_word_t  in_data,
  input  cfg_word_t cfg_data,
  output out_word_t out_data
);

  localparam int unsigned IW  = $clog2(DEPTH);
  localparam int unsigned CPW = $clog2(DEPTH + 1);
  localparam int unsigned CW  = (CAP_W > CPW) ? CAP_W : CPW;

  logic [CAP_W-1:0] capacity_r;
  logic [IW-1:0]    front_r, front_nxt;
  logic [IW-1:0]    rear_r, rear_nxt;
  logic             empty_r, empty_nxt;
  logic [IW-1:0]    list_idx_r, list_idx_nxt;
  logic             is_list_r;
  out_word_t        out_r, out_nxt;

  logic [CW-1:0]    cap_ext;
  logic [CPW-1:0]   cap_use;
  logic [IW-1:0]    cap_top;
  logic             full;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [IW-1:0]    ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  function automatic logic [IW-1:0] idx_next(input logic [IW-1:0] i,
                                             input logic [CPW-1:0] cap);
    logic [CPW-1:0] inc;
    inc = CPW'(i) + CPW'(1);
    return (inc == cap) ? '0 : inc[IW-1:0];
  endfunction

  function automatic logic [IW-1:0] idx_prev(input logic [IW-1:0] i,
                                             input logic [IW-1:0] top);
    return (i == '0) ? top : i - IW'(1);
  endfunction

  assign cap_ext = CW'(capacity_r);

  always_comb begin
    if (capacity_r == '0) begin
      cap_use = CPW'(1);
    end else if (cap_ext > CW'(DEPTH)) begin
      cap_use = CPW'(DEPTH);
    end else begin
      cap_use = cap_ext[CPW-1:0];
    end
  end

  assign cap_top = IW'(cap_use - CPW'(1));
  assign full    = !empty_r && (idx_next(rear_r, cap_use) == front_r);

  assign stat.go_read = !empty_r && (in_data.command != CMD_INSERT);
  assign stat.more    = is_list_r && !out_r.last;

  always_comb begin
    front_nxt    = front_r;
    rear_nxt     = rear_r;
    empty_nxt    = empty_r;
    list_idx_nxt = list_idx_r;
    out_nxt      = out_r;
    ram_we       = 1'b0;
    ram_waddr    = front_r;
    ram_raddr    = front_r;
    if (cmd.cfg_wr) begin
      front_nxt = '0;
      rear_nxt  = '0;
      empty_nxt = 1'b1;
    end else if (cmd.exec) begin
      out_nxt.word = '0;
      out_nxt.last = 1'b1;
      unique case (in_data.command)
        CMD_INSERT: begin
          if (full) begin
            out_nxt.status = ST_OVERFLOW;
          end else begin
            out_nxt.status = ST_OK;
            ram_we         = 1'b1;
            if (empty_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b0;
            end else begin
              front_nxt = idx_prev(front_r, cap_top);
            end
            ram_waddr = front_nxt;
          end
        end
        CMD_REM_FRONT: begin
          out_nxt.status = empty_r ? ST_UNDERFLOW : ST_OK;
          ram_raddr      = front_r;
          if (!empty_r) begin
            if (front_r == rear_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              front_nxt = idx_next(front_r, cap_use);
            end
          end
        end
        CMD_REM_REAR: begin
          out_nxt.status = empty_r ? ST_UNDERFLOW : ST_OK;
          ram_raddr      = rear_r;
          if (!empty_r) begin
            if (front_r == rear_r) begin
              front_nxt = '0;
              rear_nxt  = '0;
              empty_nxt = 1'b1;
            end else begin
              rear_nxt = idx_prev(rear_r, cap_top);
            end
          end
        end
        CMD_LIST: begin
          out_nxt.status = empty_r ? ST_EMPTY : ST_OK;
          ram_raddr      = front_r;
          list_idx_nxt   = front_r;
        end
        default: out_nxt.status = ST_OK;
      endcase
    end else if (cmd.load) begin
      out_nxt.status = ST_OK;
      out_nxt.word   = ram_rdata;
      out_nxt.last   = is_list_r ? (list_idx_r == rear_r) : 1'b1;
    end else if (cmd.next) begin
      list_idx_nxt = idx_next(list_idx_r, cap_use);
      ram_raddr    = list_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      front_r    <= '0;
      rear_r     <= '0;
      empty_r    <= 1'b1;
      is_list_r  <= 1'b0;
    end else begin
      if (cmd.cfg_wr) begin
        capacity_r <= cfg_data.capacity;
      end
      if (cmd.exec) begin
        is_list_r <= (in_data.command == CMD_LIST);
      end
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_idx_r <= list_idx_nxt;
    out_r      <= out_nxt;
  end

  cdfi_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_data.value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_data = out_r;

endmodule
